/* rtl/pipe_turn_angle_classifier_assert.svh */
// assertion macros for the turn angle classifier
`ifndef PIPE_TURN_ANGLE_CLASSIFIER_ASSERT_SVH
`define PIPE_TURN_ANGLE_CLASSIFIER_ASSERT_SVH

// property that holds at every clock unless reset is high
`define PTAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property that is checked during reset as well
`define PTAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ptac_pkg.sv */
// ----------------------------------------------------------------------------
// ptac_pkg
// constants and the arctan table shared by the turn angle classifier
// ----------------------------------------------------------------------------
package ptac_pkg;

  localparam int COORD_WIDTH_DEF     = 20;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STEPS        = 23;
  localparam int ZFRAC               = 16;
  localparam int INSCALE             = 24;
  localparam int ZW                  = 26;
  localparam int TOL_W               = 6;
  localparam int ANG_W               = 17;
  localparam int CLS_W               = 9;
  localparam int DEG_W               = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 6'd2;

  localparam logic signed [CLS_W-1:0] CLS_0    = 9'sd0;
  localparam logic signed [CLS_W-1:0] CLS_45   = 9'sd45;
  localparam logic signed [CLS_W-1:0] CLS_90   = 9'sd90;
  localparam logic signed [CLS_W-1:0] CLS_135  = 9'sd135;
  localparam logic signed [CLS_W-1:0] CLS_180  = 9'sd180;
  localparam logic signed [CLS_W-1:0] CLS_M45  = -9'sd45;
  localparam logic signed [CLS_W-1:0] CLS_M90  = -9'sd90;
  localparam logic signed [CLS_W-1:0] CLS_M135 = -9'sd135;

  // arctan(2^-i) in degrees * 2^16, rounded
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/pipe_turn_angle_classifier.sv */
// ----------------------------------------------------------------------------
// pipe_turn_angle_classifier
// pipelined direction, turn angle and class calculation for a turn node
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid / in_stall plus the valid_turn flag and three
//   points; a word is taken when in_valid is high and in_stall is low
//   output channel: out_valid / out_stall plus six result fields; a word
//   leaves when out_valid is high and out_stall is low
//   cfg_we / cfg_data write tolerance_deg (reset value 2 degrees); write only
//   while the pipe is empty
//   latency: 27 cycles from acceptance to out_valid without stalls
//   throughput: one word every cycle; the whole pipe is one shift chain, so
//   the 23 cordic stages set the latency but not the rate
//   in_stall follows out_stall while the output register holds a word: the
//   pipe advances whenever the output register is empty or being emptied,
//   so a stall loses nothing
//   reset (rst, synchronous) clears every stage valid bit and sets the
//   tolerance back to 2 degrees
// ----------------------------------------------------------------------------
module pipe_turn_angle_classifier
  import ptac_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [TOL_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          valid_turn,
  input  logic signed [COORD_WIDTH-1:0] prev_x,
  input  logic signed [COORD_WIDTH-1:0] prev_y,
  input  logic signed [COORD_WIDTH-1:0] node_x,
  input  logic signed [COORD_WIDTH-1:0] node_y,
  input  logic signed [COORD_WIDTH-1:0] next_x,
  input  logic signed [COORD_WIDTH-1:0] next_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ANG_W-1:0]       angle_prev,
  output logic signed [ANG_W-1:0]       angle_next,
  output logic signed [ANG_W-1:0]       turn_angle,
  output logic signed [CLS_W-1:0]       class_prev,
  output logic signed [CLS_W-1:0]       class_next,
  output logic [DEG_W-1:0]              turn_whole_deg
);

  `include "pipe_turn_angle_classifier_assert.svh"

  // angle scale is tied to the fixed output widths
  localparam int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF;

  // cordic datapath width: difference plus scale plus cordic growth
  localparam int DW  = COORD_WIDTH + 1;
  localparam int XW  = DW + INSCALE + 2;
  localparam int NS  = CORDIC_STEPS;
  localparam int SH  = ZFRAC - ANGLE_FRAC_BITS;
  localparam int LIM = 180 << ANGLE_FRAC_BITS;
  localparam int TW  = ANG_W + 1;

  logic adv;
  logic [TOL_W-1:0] tolerance_deg;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_deg <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance_deg <= cfg_data;
    end
  end

  // ---------------- stage 0: differences ----------------
  logic          v0, t0;
  logic signed [DW-1:0] d0 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0    <= valid_turn;
      d0[0] <= DW'(prev_x) - DW'(node_x);
      d0[1] <= DW'(prev_y) - DW'(node_y);
      d0[2] <= DW'(next_x) - DW'(node_x);
      d0[3] <= DW'(next_y) - DW'(node_y);
    end
  end

  // ---------------- stage 1: scale and quadrant pre-rotation ----------------
  logic                 v1, t1;
  logic                 zr1 [2];
  logic signed [XW-1:0] x1 [2];
  logic signed [XW-1:0] y1 [2];
  logic signed [ZW-1:0] z1 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_pre
    logic signed [XW-1:0] sx, sy;
    assign sx = XW'(d0[2*k])   <<< INSCALE;
    assign sy = XW'(d0[2*k+1]) <<< INSCALE;
    always_ff @(posedge clk) begin
      if (adv) begin
        zr1[k] <= (d0[2*k] == '0) && (d0[2*k+1] == '0);
        if (sx < 0) begin
          if (sy >= 0) begin
            x1[k] <= sy;
            y1[k] <= -sx;
            z1[k] <= ZW'(90 << ZFRAC);
          end else begin
            x1[k] <= -sy;
            y1[k] <= sx;
            z1[k] <= -ZW'(90 << ZFRAC);
          end
        end else begin
          x1[k] <= sx;
          y1[k] <= sy;
          z1[k] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1 <= t0;
    end
  end

  // ---------------- stages 2..24: cordic vectoring ----------------
  logic                 cv  [NS+1];
  logic                 ct  [NS+1];
  logic                 cz0 [NS+1][2];
  logic signed [XW-1:0] cx  [NS+1][2];
  logic signed [XW-1:0] cy  [NS+1][2];
  logic signed [ZW-1:0] cz  [NS+1][2];

  always_comb begin
    cv[0] = v1;
    ct[0] = t1;
    for (int k = 0; k < 2; k++) begin
      cz0[0][k] = zr1[k];
      cx[0][k]  = x1[k];
      cy[0][k]  = y1[k];
      cz[0][k]  = z1[k];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ct[i+1] <= ct[i];
        for (int k = 0; k < 2; k++) begin
          cz0[i+1][k] <= cz0[i][k];
          if (cy[i][k] > 0) begin
            cx[i+1][k] <= cx[i][k] + (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] - (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] + atan_val(5'(i));
          end else begin
            cx[i+1][k] <= cx[i][k] - (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] + (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] - atan_val(5'(i));
          end
        end
      end
    end
  end

  // ---------------- stage 25: round and clamp ----------------
  logic                   v2, t2;
  logic signed [ANG_W-1:0] a2 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= cv[NS];
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_rnd
    logic signed [ZW-1:0] rz;
    assign rz = (cz[NS][k] + ZW'(1 << (SH - 1))) >>> SH;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (cz0[NS][k]) begin
          a2[k] <= '0;
        end else if (rz > ZW'(LIM)) begin
          a2[k] <= ANG_W'(LIM);
        end else if (rz < -ZW'(LIM)) begin
          a2[k] <= -ANG_W'(LIM);
        end else begin
          a2[k] <= ANG_W'(rz);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2 <= ct[NS];
    end
  end

  // ---------------- stage 26: turn angle and classes ----------------
  function automatic logic signed [CLS_W-1:0] classify(
    input logic signed [ANG_W-1:0] v, input logic signed [TW-1:0] tol);
    logic signed [TW-1:0] w, u90, u180;
    logic signed [CLS_W-1:0] c;
    w    = TW'(v);
    u90  = TW'(90 << ANGLE_FRAC_BITS);
    u180 = TW'(180 << ANGLE_FRAC_BITS);
    if (w < tol && w > -tol)                          c = CLS_0;
    else if (w < u90 + tol && w > u90 - tol)          c = CLS_90;
    else if (w < -u180 + tol || w > u180 - tol)       c = CLS_180;
    else if (w < -u90 + tol && w > -u90 - tol)        c = CLS_M90;
    else if (w < u90 && w > 0)                        c = CLS_45;
    else if (w > u90)                                 c = CLS_135;
    else if (w > -u90 && w < 0)                       c = CLS_M45;
    else if (w < -u90)                                c = CLS_M135;
    else                                              c = CLS_0;
    return c;
  endfunction

  logic                    v3, t3;
  logic signed [ANG_W-1:0] a3 [2];
  logic signed [ANG_W-1:0] ta3;
  logic signed [CLS_W-1:0] c3 [2];
  logic [TOL_W-1:0]        tol3;
  logic signed [TW-1:0]    tolf, dif, twr;

  assign tolf = TW'({1'b0, tolerance_deg}) <<< ANGLE_FRAC_BITS;
  assign dif  = TW'(a2[1]) - TW'(a2[0]);
  always_comb begin
    twr = dif;
    if (dif > TW'(LIM)) twr = dif - TW'(2 * LIM);
    if (twr < -TW'(LIM)) twr = twr + TW'(2 * LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3    <= t2;
      a3[0] <= a2[0];
      a3[1] <= a2[1];
      ta3   <= ANG_W'(twr);
      c3[0] <= classify(a2[0], tolf);
      c3[1] <= classify(a2[1], tolf);
      tol3  <= tolerance_deg;
    end
  end

  // ---------------- stage 27: whole degrees, snap, output register ----------------
  logic [ANG_W-1:0]      mag;
  logic signed [10:0]    wh, d90, d180;
  logic [DEG_W-1:0]      whs;
  logic                  rightc;

  assign mag    = ta3[ANG_W-1] ? ANG_W'(-ta3) : ANG_W'(ta3);
  assign wh     = 11'(mag >> ANGLE_FRAC_BITS);
  assign d90    = (wh >= 11'sd90) ? wh - 11'sd90 : 11'sd90 - wh;
  assign d180   = (wh >= 11'sd180) ? wh - 11'sd180 : 11'sd180 - wh;
  assign rightc = (c3[0] == CLS_0) || (c3[0] == CLS_90) || (c3[0] == CLS_180)
               || (c3[0] == CLS_M90);
  always_comb begin
    whs = DEG_W'(wh);
    if (rightc) begin
      if (d90 <= 11'(tol3))       whs = DEG_W'(90);
      else if (d180 <= 11'(tol3)) whs = DEG_W'(180);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (t3) begin
        angle_prev     <= a3[0];
        angle_next     <= a3[1];
        turn_angle     <= ta3;
        class_prev     <= c3[0];
        class_next     <= c3[1];
        turn_whole_deg <= whs;
      end else begin
        angle_prev     <= '0;
        angle_next     <= '0;
        turn_angle     <= '0;
        class_prev     <= '0;
        class_next     <= '0;
        turn_whole_deg <= '0;
      end
    end
  end

  // ---------------- checks ----------------
  `PTAC_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(turn_angle),
    "stalled output word changed")
  `PTAC_ASSERT(a_whole_range, out_valid |-> turn_whole_deg <= DEG_W'(180),
    "turn degrees above 180")
  `PTAC_ASSERT(a_in_stall, in_stall == (out_valid && out_stall),
    "input stall does not follow output register")
  `PTAC_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !v0,
    "reset did not clear the pipe")

endmodule

/* tb/pipe_turn_angle_classifier_test.sv */
// ----------------------------------------------------------------------------
// pipe_turn_angle_classifier_test
// self-checking bench for the turn angle classifier: a queue-fed driver sends
// point triples with random gaps, a bit-exact cordic predictor computes each
// word's expected result, and a monitor compares results in order
// ----------------------------------------------------------------------------
module pipe_turn_angle_classifier_test;
  import ptac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int FB      = ANGLE_FRAC_BITS_DEF;
  localparam int LATENCY = 27;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic          turn;
    logic [CW-1:0] px, py, nx, ny, qx, qy;
  } point_word_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] a_prev, a_next, turn;
    logic signed [CLS_W-1:0] c_prev, c_next;
    logic [DEG_W-1:0]        whole;
  } angle_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic valid_turn = 1'b0;
  logic signed [CW-1:0] prev_x = '0, prev_y = '0, node_x = '0, node_y = '0;
  logic signed [CW-1:0] next_x = '0, next_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANG_W-1:0] angle_prev, angle_next, turn_angle;
  logic signed [CLS_W-1:0] class_prev, class_next;
  logic [DEG_W-1:0] turn_whole_deg;

  pipe_turn_angle_classifier u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .valid_turn(valid_turn),
    .prev_x(prev_x), .prev_y(prev_y), .node_x(node_x), .node_y(node_y),
    .next_x(next_x), .next_y(next_y), .out_valid(out_valid),
    .out_stall(out_stall), .angle_prev(angle_prev), .angle_next(angle_next),
    .turn_angle(turn_angle), .class_prev(class_prev), .class_next(class_next),
    .turn_whole_deg(turn_whole_deg)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shared state of the bench
  point_word_t   pending_words[$];
  angle_result_t expected_angles[$];
  logic [TOL_W-1:0] tol_model = TOL_RESET;
  longint cycle_count = 0;
  int     fail_count = 0;
  int     results_seen = 0;
  int     hold_cycles = 0;   // long receiver hold-off requested by the stimulus
  logic   in_stall_q = 1'b0;
  logic   out_valid_q = 1'b0;

  // arctan table, degrees * 2^16
  longint atan_deg16[CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

  // cordic vectoring, all shifts arithmetic (>>> floors)
  function automatic longint direction_of(longint dy, longint dx);
    longint x, y, z, xs, ys, r, t;
    longint lim;
    lim = 180 <<< FB;
    if (dx == 0 && dy == 0) return 0;
    x = dx <<< INSCALE;
    y = dy <<< INSCALE;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 <<< ZFRAC;
      end else begin
        x = -y; y = t; z = -(90 <<< ZFRAC);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += atan_deg16[i];
      end else begin
        x = x - ys; y = y + xs; z -= atan_deg16[i];
      end
    end
    r = (z + (longint'(1) <<< (ZFRAC - FB - 1))) >>> (ZFRAC - FB);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // strict tests, first match wins
  function automatic logic signed [CLS_W-1:0] snap_class(longint v, longint tol);
    longint u;
    u = longint'(1) <<< FB;
    if (v < tol && v > -tol) return CLS_0;
    if (v < 90*u + tol && v > 90*u - tol) return CLS_90;
    if (v < -180*u + tol || v > 180*u - tol) return CLS_180;
    if (v < -90*u + tol && v > -90*u - tol) return CLS_M90;
    if (v < 90*u && v > 0) return CLS_45;
    if (v > 90*u) return CLS_135;
    if (v > -90*u && v < 0) return CLS_M45;
    if (v < -90*u) return CLS_M135;
    return CLS_0;
  endfunction

  function automatic angle_result_t predict_turn(point_word_t w, logic [TOL_W-1:0] tolv);
    angle_result_t r;
    longint a1, a2, t, whole, d90, d180, half, td;
    half = 180 <<< FB;
    td = longint'(tolv);
    r = '0;
    if (!w.turn) return r;
    a1 = direction_of(longint'($signed(w.py)) - longint'($signed(w.ny)),
                      longint'($signed(w.px)) - longint'($signed(w.nx)));
    a2 = direction_of(longint'($signed(w.qy)) - longint'($signed(w.ny)),
                      longint'($signed(w.qx)) - longint'($signed(w.nx)));
    t = a2 - a1;
    if (t > half) t -= 2*half;
    if (t < -half) t += 2*half;
    r.a_prev = a1[ANG_W-1:0];
    r.a_next = a2[ANG_W-1:0];
    r.turn   = t[ANG_W-1:0];
    r.c_prev = snap_class(a1, td <<< FB);
    r.c_next = snap_class(a2, td <<< FB);
    whole = (t < 0 ? -t : t) >>> FB;
    // right-angle snap only when the incoming direction sits on an axis
    if (r.c_prev == CLS_0 || r.c_prev == CLS_90 || r.c_prev == CLS_180 ||
        r.c_prev == CLS_M90) begin
      d90 = whole - 90;   if (d90 < 0) d90 = -d90;
      d180 = whole - 180; if (d180 < 0) d180 = -d180;
      if (d90 <= td) whole = 90;
      else if (d180 <= td) whole = 180;
    end
    r.whole = whole[DEG_W-1:0];
    return r;
  endfunction

  // ---- driver: one word from the queue, random gap after each acceptance ----
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        // word went in at the last rising edge
        void'(pending_words.pop_front());
        send_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_words.size() > 0) begin
        in_valid   <= 1'b1;
        valid_turn <= pending_words[0].turn;
        prev_x <= pending_words[0].px; prev_y <= pending_words[0].py;
        node_x <= pending_words[0].nx; node_y <= pending_words[0].ny;
        next_x <= pending_words[0].qx; next_y <= pending_words[0].qy;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // acceptance seen at the rising edge; prediction uses the tolerance in force
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (!rst && in_valid && !in_stall)
      expected_angles.push_back(predict_turn(pending_words[0], tol_model));
  end

  // ---- receiver stall: random per word, plus the long hold-off ----
  int recv_gap = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (recv_gap > 0) begin
      out_stall <= 1'b1;
      recv_gap--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid_q) begin
        recv_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    angle_result_t exp_r;
    cycle_count++;
    out_valid_q <= out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_angles.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_r = expected_angles.pop_front();
        if (angle_prev !== exp_r.a_prev) begin
          $error("angle_prev expected %0d got %0d", exp_r.a_prev, angle_prev);
          fail_count++;
        end
        if (angle_next !== exp_r.a_next) begin
          $error("angle_next expected %0d got %0d", exp_r.a_next, angle_next);
          fail_count++;
        end
        if (turn_angle !== exp_r.turn) begin
          $error("turn_angle expected %0d got %0d", exp_r.turn, turn_angle);
          fail_count++;
        end
        if (class_prev !== exp_r.c_prev) begin
          $error("class_prev expected %0d got %0d", exp_r.c_prev, class_prev);
          fail_count++;
        end
        if (class_next !== exp_r.c_next) begin
          $error("class_next expected %0d got %0d", exp_r.c_next, class_next);
          fail_count++;
        end
        if (turn_whole_deg !== exp_r.whole) begin
          $error("turn_whole_deg expected %0d got %0d", exp_r.whole, turn_whole_deg);
          fail_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return logic'(1) ? CW'($urandom) : '0;
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return {1'b1, {(CW-1){1'b0}}};
      default: return CW'($urandom);
    endcase
  endfunction

  // point relative to the node, often on or near an axis or diagonal
  function automatic void near_point(logic [CW-1:0] n_x, logic [CW-1:0] n_y,
                                     output logic [CW-1:0] p_x, output logic [CW-1:0] p_y);
    int r, e, kind;
    r = int'($urandom_range(1, 4000));
    e = int'($urandom_range(0, 120)) - 60;
    kind = int'($urandom_range(0, 9));
    case (kind)
      0: begin p_x = CW'(n_x + r); p_y = CW'(n_y + e); end
      1: begin p_x = CW'(n_x - r); p_y = CW'(n_y + e); end
      2: begin p_x = CW'(n_x + e); p_y = CW'(n_y + r); end
      3: begin p_x = CW'(n_x + e); p_y = CW'(n_y - r); end
      4: begin p_x = CW'(n_x + r); p_y = CW'(n_y + r + e); end
      5: begin p_x = CW'(n_x - r); p_y = CW'(n_y - r + e); end
      6: begin
        p_x = CW'(n_x + $urandom_range(0, 9));
        p_y = CW'(n_y - $urandom_range(0, 9));
      end
      default: begin
        p_x = CW'(n_x + (int'($urandom_range(0, 8000)) - 4000));
        p_y = CW'(n_y + (int'($urandom_range(0, 8000)) - 4000));
      end
    endcase
  endfunction

  function automatic point_word_t make_word(bit wild);
    point_word_t w;
    w.turn = ($urandom_range(0, 9) != 0);
    if (wild) begin
      w.px = rand_coord(); w.py = rand_coord(); w.nx = rand_coord();
      w.ny = rand_coord(); w.qx = rand_coord(); w.qy = rand_coord();
    end else begin
      w.nx = CW'($urandom);
      w.ny = CW'($urandom);
      near_point(w.nx, w.ny, w.px, w.py);
      near_point(w.nx, w.ny, w.qx, w.qy);
    end
    return w;
  endfunction

  function automatic point_word_t rel_word(int dpx, int dpy, int dqx, int dqy);
    point_word_t w;
    w.turn = 1'b1;
    w.nx = CW'(1000); w.ny = CW'(-2000);
    w.px = CW'(w.nx + dpx); w.py = CW'(w.ny + dpy);
    w.qx = CW'(w.nx + dqx); w.qy = CW'(w.ny + dqy);
    return w;
  endfunction

  task automatic drain_pipe();
    while (pending_words.size() > 0 || expected_angles.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // idle-only register write at a falling edge
  task automatic write_tolerance(logic [TOL_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    tol_model = v;
  endtask

  task automatic send_random(int n, int wild_pct);
    for (int i = 0; i < n; i++)
      pending_words.push_back(make_word($urandom_range(0, 99) < wild_pct));
  endtask

  logic [TOL_W-1:0] tol_plan[6] = '{6'd0, 6'd44, 6'd63, 6'd5, 6'd1, 6'd20};

  initial begin
    point_word_t w;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at the reset tolerance
    pending_words.push_back(rel_word(0, 0, 0, 0));           // coincident points
    pending_words.push_back(rel_word(-100, 0, 100, 0));      // straight through
    pending_words.push_back(rel_word(-100, 0, 0, 100));      // right angle
    pending_words.push_back(rel_word(100, 0, 0, -100));
    pending_words.push_back(rel_word(-100, -1, -100, 1));    // wrap across 180
    pending_words.push_back(rel_word(100, 100, -100, -100));
    pending_words.push_back(rel_word(-100, 100, 100, -100));
    pending_words.push_back(rel_word(0, 5, 5, 0));
    pending_words.push_back(rel_word(0, -5, -5, 0));
    pending_words.push_back(rel_word(3, 100, -100, 4));      // near axis, tolerance
    w = rel_word(0, 0, 0, 0);
    w.turn = 1'b0; w.px = '1; w.qy = '1;                     // invalid flag
    pending_words.push_back(w);
    w.turn = 1'b1;                                           // extreme coordinates
    w.px = {1'b0, {(CW-1){1'b1}}}; w.py = {1'b1, {(CW-1){1'b0}}};
    w.nx = {1'b1, {(CW-1){1'b0}}}; w.ny = {1'b0, {(CW-1){1'b1}}};
    w.qx = {1'b1, {(CW-1){1'b0}}}; w.qy = {1'b1, {(CW-1){1'b0}}};
    pending_words.push_back(w);
    w.px = '1; w.py = '1; w.nx = '0; w.ny = '0; w.qx = '1; w.qy = '0;
    pending_words.push_back(w);
    drain_pipe();

    // tolerance zero: exact 0, 90 and -90 directions fall through to class 0, 180 lands in class 135
    write_tolerance(6'd0);
    pending_words.push_back(rel_word(0, 100, -100, 0));
    pending_words.push_back(rel_word(100, 0, 0, -100));
    pending_words.push_back(rel_word(-100, 0, 100, 0));
    drain_pipe();

    // random phases across tolerance settings
    foreach (tol_plan[k]) begin
      write_tolerance(tol_plan[k]);
      send_random(150, 25);
      drain_pipe();
    end

    // long receiver hold-off while the sender keeps offering words
    hold_cycles = 200;
    send_random(120, 20);
    drain_pipe();

    // burst, then the sender waits for everything to come back
    write_tolerance(TOL_RESET);
    send_random(60, 20);
    drain_pipe();
    send_random(50, 20);
    drain_pipe();

    $display("covered %0d result words over %0d tolerance settings",
             results_seen, 7);
    $display("including invalid turns, coincident points and a long output stall");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
